[rtl/yuv_plane_stride_offset_calc_macros.svh]
// ----------------------------------------------------------------------------
// YUV layout calculator assertion macros
// Implication checks clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef YUV_PLANE_STRIDE_OFFSET_CALC_MACROS_SVH
`define YUV_PLANE_STRIDE_OFFSET_CALC_MACROS_SVH

// same-cycle implication
`define YUVPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("yuvps: same-cycle check failed");

// next-cycle implication
`define YUVPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("yuvps: next-cycle check failed");

`endif

[rtl/yuvps_pkg.sv]
// ----------------------------------------------------------------------------
// YUV layout calculator package
// Field widths, pipeline sizing and pixel format codes.
// ----------------------------------------------------------------------------
`default_nettype none

package yuvps_pkg;

  localparam int unsigned FIELD_W         = 15;  // frame width / height
  localparam int unsigned ALIGN_W         = 13;  // alignment registers
  localparam int unsigned STRIDE_W        = 16;
  localparam int unsigned OFFSET_W        = 32;
  localparam int unsigned STEPS_PER_STAGE = 4;   // remainder bits per stage

  typedef enum logic [2:0] {
    MODE_YUV420P   = 3'd0,
    MODE_NV12      = 3'd1,
    MODE_NV21      = 3'd2,
    MODE_UYVY422   = 3'd3,
    MODE_YUYV422   = 3'd4,
    MODE_P010LE    = 3'd5,
    MODE_YUV420P10 = 3'd6,
    MODE_UNSUP     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    CFG_WIDTH_ALIGN  = 2'd0,
    CFG_HEIGHT_ALIGN = 2'd1
  } cfg_idx_e;

endpackage

`default_nettype wire

[rtl/yuvps_rnd.sv]
// ----------------------------------------------------------------------------
// Pipelined round-up unit
// y = x rounded up to a multiple of a (a == 0 passes x). Restoring remainder,
// SPS bits per stage, then one stage for the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvps_rnd #(
  parameter int unsigned XW  = yuvps_pkg::FIELD_W,
  parameter int unsigned AW  = yuvps_pkg::ALIGN_W,
  parameter int unsigned SPS = yuvps_pkg::STEPS_PER_STAGE,
  localparam int unsigned NST = (XW + SPS - 1) / SPS,
  localparam int unsigned XP  = NST * SPS
) (
  input  wire logic          clk_i,
  input  wire logic [NST:0]  en_i,
  input  wire logic [XW-1:0] x_i,
  input  wire logic [AW-1:0] a_i,
  output logic      [XW:0]   y_o
);

  logic [XP-1:0] x_q [NST];
  logic [AW-1:0] r_q [NST];
  logic [XW:0]   y_d, y_q;

  for (genvar j = 0; j < NST; j++) begin : g_st
    logic [XP-1:0] x_in;
    logic [AW-1:0] r_in, r_nx;

    if (j == 0) begin : g_first
      assign x_in = {{(XP-XW){1'b0}}, x_i};
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[j-1];
      assign r_in = r_q[j-1];
    end

    always_comb begin
      logic [AW:0]   t;
      logic [AW-1:0] r;
      r = r_in;
      for (int s = 0; s < SPS; s++) begin
        t = {r, x_in[XP-1-j*SPS-s]};
        if (t >= {1'b0, a_i}) begin
          t = t - {1'b0, a_i};
        end
        r = t[AW-1:0];
      end
      r_nx = r;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        x_q[j] <= x_in;
        r_q[j] <= r_nx;
      end
    end
  end

  always_comb begin
    logic [AW-1:0] pad;
    pad = (r_q[NST-1] == '0) ? '0 : a_i - r_q[NST-1];
    if (a_i == '0) begin
      y_d = {1'b0, x_q[NST-1][XW-1:0]};
    end else begin
      y_d = {1'b0, x_q[NST-1][XW-1:0]} + {{(XW+1-AW){1'b0}}, pad};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NST]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

[rtl/yuv_plane_stride_offset_calc.sv]
// ----------------------------------------------------------------------------
// YUV frame buffer layout calculator
// Per request: aligned strides, plane offsets, plane count and buffer size.
// ----------------------------------------------------------------------------
// One request per cycle is accepted unless stalled and one result per
// request leaves: 5 stages round width and height up to their alignments,
// 6 stages round the row to the stride alignment, one stage multiplies by
// the aligned height and one stage forms offsets and size into the output
// register. The depth is set by the round-up remainder units, 4 quotient
// bits per stage. Each stage holds its beat while the stage after it holds,
// so a stalled output only fills the pipe. The user must write alignments
// only while no request is in flight; the block does not enforce it.
`default_nettype none

`include "yuv_plane_stride_offset_calc_macros.svh"

module yuv_plane_stride_offset_calc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [14:0] frame_width_i,
  input  wire logic [14:0] frame_height_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             supported_o,
  output logic [1:0]       plane_count_o,
  output logic [15:0]      y_pitch_o,
  output logic [15:0]      u_stride_o,
  output logic [15:0]      v_pitch_o,
  output logic [31:0]      u_offset_o,
  output logic [31:0]      v_offset_o,
  output logic [31:0]      buffer_size_o
);

  localparam int unsigned FW  = yuvps_pkg::FIELD_W;
  localparam int unsigned AL  = yuvps_pkg::ALIGN_W;
  localparam int unsigned SPS = yuvps_pkg::STEPS_PER_STAGE;
  localparam int unsigned XB  = FW + 2;
  localparam int unsigned NA  = (FW + SPS - 1) / SPS + 1;
  localparam int unsigned NB  = (XB + SPS - 1) / SPS + 1;
  localparam int unsigned IM  = NA + NB;
  localparam int unsigned NS  = NA + NB + 2;
  localparam int unsigned IF  = NS - 1;

  // configuration
  logic [AL-1:0] wa_q, ha_q;
  logic [AL:0]   sa;
  logic [AL-1:0] sa_half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q <= '0;
      ha_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == yuvps_pkg::CFG_WIDTH_ALIGN) begin
        wa_q <= cfg_data_i;
      end
      if (cfg_idx_i == yuvps_pkg::CFG_HEIGHT_ALIGN) begin
        ha_q <= cfg_data_i;
      end
    end
  end

  // row alignment: even, at least 2
  assign sa      = (wa_q < AL'(2)) ? (AL+1)'(2) : {1'b0, wa_q} + {{AL{1'b0}}, wa_q[0]};
  assign sa_half = sa[AL:1];

  // stage valids and advance chain
  logic [NS-1:0] v_q, en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    if (k == NS - 1) begin : g_last
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  // width / height alignment
  logic [FW:0] aw, ah;
  yuvps_pkg::mode_e amode_q [NA];

  yuvps_rnd #(.XW(FW), .AW(AL), .SPS(SPS)) u_rnd_w (
    .clk_i, .en_i(en[NA-1:0]), .x_i(frame_width_i), .a_i(wa_q), .y_o(aw)
  );

  yuvps_rnd #(.XW(FW), .AW(AL), .SPS(SPS)) u_rnd_h (
    .clk_i, .en_i(en[NA-1:0]), .x_i(frame_height_i), .a_i(ha_q), .y_o(ah)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      amode_q[0] <= yuvps_pkg::mode_e'(mode_i);
    end
    for (int k = 1; k < NA; k++) begin
      if (en[k]) begin
        amode_q[k] <= amode_q[k-1];
      end
    end
  end

  // stride alignment
  logic [XB-1:0] b1_x;
  logic [XB:0]   b1_y, b2_y;
  yuvps_pkg::mode_e bmode_q [NB];
  logic [FW:0]      baw_q [NB];
  logic [FW:0]      bah_q [NB];

  assign b1_x = (amode_q[NA-1] == yuvps_pkg::MODE_P010LE ||
                 amode_q[NA-1] == yuvps_pkg::MODE_YUV420P10) ? {aw, 1'b0} : {1'b0, aw};

  yuvps_rnd #(.XW(XB), .AW(AL+1), .SPS(SPS)) u_rnd_ys (
    .clk_i, .en_i(en[IM-1:NA]), .x_i(b1_x), .a_i(sa), .y_o(b1_y)
  );

  yuvps_rnd #(.XW(XB), .AW(AL), .SPS(SPS)) u_rnd_us (
    .clk_i, .en_i(en[IM-1:NA]), .x_i({1'b0, aw}), .a_i(sa_half), .y_o(b2_y)
  );

  always_ff @(posedge clk_i) begin
    if (en[NA]) begin
      bmode_q[0] <= amode_q[NA-1];
      baw_q[0]   <= aw;
      bah_q[0]   <= ah;
    end
    for (int j = 1; j < NB; j++) begin
      if (en[NA+j]) begin
        bmode_q[j] <= bmode_q[j-1];
        baw_q[j]   <= baw_q[j-1];
        bah_q[j]   <= bah_q[j-1];
      end
    end
  end

  // strides and products
  logic [XB:0] ys_d, us_d;
  yuvps_pkg::mode_e mmode_q;
  logic [15:0] mys_q, mus_q;
  logic [31:0] muo_q, msz_q;
  logic [32:0] mvs_q;
  logic [33:0] puo, pvs;
  logic [31:0] psz;

  always_comb begin
    ys_d = b1_y;
    us_d = '0;
    unique case (bmode_q[NB-1])
      yuvps_pkg::MODE_UYVY422, yuvps_pkg::MODE_YUYV422: begin
        ys_d = {1'b0, baw_q[NB-1], 1'b0};
      end
      yuvps_pkg::MODE_YUV420P:   us_d = {1'b0, b1_y[XB:1]};
      yuvps_pkg::MODE_NV12, yuvps_pkg::MODE_NV21,
      yuvps_pkg::MODE_P010LE:    us_d = b1_y;
      yuvps_pkg::MODE_YUV420P10: us_d = b2_y;
      default:                   us_d = '0;
    endcase
  end

  assign puo = {16'd0, ys_d} * {18'd0, bah_q[NB-1]};
  assign pvs = {16'd0, us_d} * {18'd0, bah_q[NB-1]};
  assign psz = {16'd0, baw_q[NB-1]} * {16'd0, bah_q[NB-1]};

  always_ff @(posedge clk_i) begin
    if (en[IM]) begin
      mmode_q <= bmode_q[NB-1];
      mys_q   <= ys_d[15:0];
      mus_q   <= us_d[15:0];
      muo_q   <= puo[31:0];
      mvs_q   <= pvs[32:0];
      msz_q   <= psz;
    end
  end

  // offsets, size, output register
  logic [33:0] p3;
  logic [31:0] vo;
  logic        sup_d;
  logic [1:0]  pc_d;
  logic [15:0] ys_o_d, us_o_d, vs_o_d;
  logic [31:0] uo_d, vo_d, sz_d;
  logic        sup_q;
  logic [1:0]  pc_q;
  logic [15:0] ys_q, us_q, vs_q;
  logic [31:0] uo_q, vo_q, sz_q;

  assign p3 = {2'b0, msz_q} + {1'b0, msz_q, 1'b0};
  assign vo = muo_q + mvs_q[32:1];

  always_comb begin
    sup_d  = 1'b1;
    pc_d   = 2'd0;
    ys_o_d = mys_q;
    us_o_d = '0;
    vs_o_d = '0;
    uo_d   = '0;
    vo_d   = '0;
    sz_d   = '0;
    unique case (mmode_q)
      yuvps_pkg::MODE_YUV420P, yuvps_pkg::MODE_YUV420P10: begin
        pc_d   = 2'd3;
        us_o_d = mus_q;
        vs_o_d = mus_q;
        uo_d   = muo_q;
        vo_d   = vo;
        sz_d   = (mmode_q == yuvps_pkg::MODE_YUV420P) ? p3[32:1] : p3[31:0];
      end
      yuvps_pkg::MODE_NV12, yuvps_pkg::MODE_NV21, yuvps_pkg::MODE_P010LE: begin
        pc_d   = 2'd2;
        us_o_d = mus_q;
        uo_d   = muo_q;
        sz_d   = (mmode_q == yuvps_pkg::MODE_P010LE) ? p3[31:0] : p3[32:1];
      end
      yuvps_pkg::MODE_UYVY422, yuvps_pkg::MODE_YUYV422: begin
        pc_d = 2'd1;
        sz_d = {msz_q[30:0], 1'b0};
      end
      default: begin
        sup_d  = 1'b0;
        ys_o_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[IF]) begin
      sup_q <= sup_d;
      pc_q  <= pc_d;
      ys_q  <= ys_o_d;
      us_q  <= us_o_d;
      vs_q  <= vs_o_d;
      uo_q  <= uo_d;
      vo_q  <= vo_d;
      sz_q  <= sz_d;
    end
  end

  assign out_valid_o   = v_q[IF];
  assign supported_o   = sup_q;
  assign plane_count_o = pc_q;
  assign y_pitch_o     = ys_q;
  assign u_stride_o    = us_q;
  assign v_pitch_o     = vs_q;
  assign u_offset_o    = uo_q;
  assign v_offset_o    = vo_q;
  assign buffer_size_o = sz_q;

  // checks
  `YUVPS_ASSERT_IMP(a_unsup_zero, out_valid_o && !supported_o,
                    buffer_size_o == 32'd0 && plane_count_o == 2'd0 && y_pitch_o == 16'd0)
  `YUVPS_ASSERT_IMP(a_no_third_plane, out_valid_o && plane_count_o != 2'd3,
                    v_offset_o == 32'd0 && v_pitch_o == 16'd0)
  `YUVPS_ASSERT_IMP(a_sup_planes, out_valid_o && supported_o, plane_count_o != 2'd0)
  `YUVPS_ASSERT_NXT(a_mult_hold, v_q[IM] && !en[IM], v_q[IM])

endmodule

`default_nettype wire
